// ----- sv/fts_pkg.sv -----
`timescale 1ns / 1ps

package fts_pkg;

	// Fixed field widths at the ports
	localparam int PID_W   = 8;
	localparam int SLOT_W  = 4;
	localparam int PORT_TW = 16;
	localparam int REM_W   = 16;
	localparam int NP_W    = 5;
	localparam int SW_W    = 16;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SEL  = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	// Write strobes into the process table
	typedef struct packed {
		logic load;
		logic upd_wait;
		logic upd_rem;
		logic upd_resp;
	} tbl_wr_t;

endpackage

// ----- sv/fts_table.sv -----
`timescale 1ns / 1ps

module fts_table #(
	parameter int MAX_ENTRIES = 16,
	parameter int TIME_BITS   = 16,
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  logic                          clk,
	input  logic [IW-1:0]                 raddr,
	input  logic [IW-1:0]                 waddr,
	input  fts_pkg::tbl_wr_t              wr,
	input  logic [fts_pkg::PID_W-1:0]     w_pid,
	input  logic [TIME_BITS-1:0]          w_arr,
	input  logic [fts_pkg::REM_W-1:0]     w_rem,
	input  logic [TIME_BITS-1:0]          w_resp,
	input  logic [TIME_BITS-1:0]          w_wait,
	input  logic [TIME_BITS-1:0]          w_max,
	output logic [fts_pkg::PID_W-1:0]     r_pid,
	output logic [TIME_BITS-1:0]          r_arr,
	output logic [fts_pkg::REM_W-1:0]     r_rem,
	output logic [TIME_BITS-1:0]          r_resp,
	output logic [TIME_BITS-1:0]          r_wait,
	output logic [TIME_BITS-1:0]          r_max
);

	logic [fts_pkg::PID_W-1:0] pid_mem  [MAX_ENTRIES];
	logic [TIME_BITS-1:0]      arr_mem  [MAX_ENTRIES];
	logic [fts_pkg::REM_W-1:0] rem_mem  [MAX_ENTRIES];
	logic [TIME_BITS-1:0]      resp_mem [MAX_ENTRIES];
	logic [TIME_BITS-1:0]      wait_mem [MAX_ENTRIES];
	logic [TIME_BITS-1:0]      max_mem  [MAX_ENTRIES];

	// Write one entry, read one entry each cycle
	always_ff @(posedge clk) begin
		if (wr.load) begin
			pid_mem[waddr] <= w_pid;
			arr_mem[waddr] <= w_arr;
		end
		if (wr.load || wr.upd_rem) begin
			rem_mem[waddr] <= w_rem;
		end
		if (wr.load || wr.upd_resp) begin
			resp_mem[waddr] <= w_resp;
		end
		if (wr.load || wr.upd_wait) begin
			wait_mem[waddr] <= w_wait;
			max_mem[waddr]  <= w_max;
		end
		r_pid  <= pid_mem[raddr];
		r_arr  <= arr_mem[raddr];
		r_rem  <= rem_mem[raddr];
		r_resp <= resp_mem[raddr];
		r_wait <= wait_mem[raddr];
		r_max  <= max_mem[raddr];
	end

endmodule

// ----- sv/fts_core.sv -----
`timescale 1ns / 1ps

module fts_core #(
	parameter int MAX_ENTRIES = 16,
	parameter int TIME_BITS   = 16,
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CW = $clog2(MAX_ENTRIES + 1),
	localparam int NW = (CW > fts_pkg::NP_W) ? CW : fts_pkg::NP_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [fts_pkg::NP_W-1:0]        num_processes,
	input  logic                            start,
	input  logic                            mode,
	input  logic [fts_pkg::SLOT_W-1:0]      slot,
	input  logic [fts_pkg::PID_W-1:0]       proc_id,
	input  logic [fts_pkg::PORT_TW-1:0]     arrive_tick,
	input  logic [fts_pkg::REM_W-1:0]       burst_time,
	output logic                            busy,
	// table side
	output logic [IW-1:0]                   tbl_raddr,
	output logic [IW-1:0]                   tbl_waddr,
	output fts_pkg::tbl_wr_t                tbl_wr,
	output logic [fts_pkg::PID_W-1:0]       tbl_wpid,
	output logic [TIME_BITS-1:0]            tbl_warr,
	output logic [fts_pkg::REM_W-1:0]       tbl_wrem,
	output logic [TIME_BITS-1:0]            tbl_wresp,
	output logic [TIME_BITS-1:0]            tbl_wwait,
	output logic [TIME_BITS-1:0]            tbl_wmax,
	input  logic [fts_pkg::PID_W-1:0]       rd_pid,
	input  logic [TIME_BITS-1:0]            rd_arr,
	input  logic [fts_pkg::REM_W-1:0]       rd_rem,
	input  logic [TIME_BITS-1:0]            rd_resp,
	input  logic [TIME_BITS-1:0]            rd_wait,
	input  logic [TIME_BITS-1:0]            rd_max,
	// results
	output logic                            result_valid,
	output logic [fts_pkg::PORT_TW-1:0]     tick_time,
	output logic                            idle,
	output logic [fts_pkg::PID_W-1:0]       running_id,
	output logic                            finished,
	output logic [fts_pkg::PORT_TW-1:0]     done_tick,
	output logic [fts_pkg::PORT_TW-1:0]     response_delay,
	output logic [fts_pkg::PORT_TW-1:0]     longest_wait,
	output logic [fts_pkg::SW_W-1:0]        switch_count,
	output logic                            all_done
);

	localparam logic [TIME_BITS-1:0]     TMAX  = '1;
	localparam logic [fts_pkg::SW_W-1:0] SWMAX = '1;

	fts_pkg::state_t state_q;

	logic [CW-1:0]              scan_q;
	logic                       v_s1;
	logic [IW-1:0]              idx_s1;
	logic                       rv_q;
	logic [IW-1:0]              run_q;
	logic                       prev_v_q;
	logic [fts_pkg::PID_W-1:0]  prev_pid_q;
	logic [fts_pkg::SW_W-1:0]   sw_q;
	logic [MAX_ENTRIES-1:0]     done_q;
	logic [MAX_ENTRIES-1:0]     started_q;
	logic                       found_q;
	logic                       fin_q;
	logic [TIME_BITS-1:0]       now_q;
	logic [TIME_BITS-1:0]       best_arr_q;
	logic [fts_pkg::PID_W-1:0]  best_pid_q;
	logic [IW-1:0]              best_idx_q;
	logic [fts_pkg::PID_W-1:0]  run_pid_q;
	logic [TIME_BITS-1:0]       resp_out_q;
	logic [TIME_BITS-1:0]       lw_q;

	logic [NW-1:0]              np_w;
	logic [CW-1:0]              n_use;
	logic [MAX_ENTRIES-1:0]     use_mask;
	logic                       issue;
	logic                       slot_ok;
	logic                       do_load;
	logic                       do_tick;
	logic                       run_stale;
	logic                       le_t;
	logic                       elig;
	logic                       better;
	logic                       found_d;
	logic [TIME_BITS-1:0]       best_arr_d;
	logic [fts_pkg::PID_W-1:0]  best_pid_d;
	logic [IW-1:0]              best_idx_d;
	logic                       proc_upd;
	logic                       is_run;
	logic [fts_pkg::REM_W-1:0]  rem_new;
	logic [TIME_BITS-1:0]       t_minus_arr;
	logic [TIME_BITS-1:0]       w_inc;
	logic [TIME_BITS-1:0]       max_new;
	logic [TIME_BITS-1:0]       t_inc;
	logic [fts_pkg::SW_W-1:0]   sw_inc;

	// Clamp the entry count to 1 .. MAX_ENTRIES
	always_comb begin
		np_w = NW'(num_processes);
		if (np_w == '0) begin
			n_use = CW'(1);
		end else if (np_w > NW'(MAX_ENTRIES)) begin
			n_use = CW'(MAX_ENTRIES);
		end else begin
			n_use = CW'(np_w);
		end
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			use_mask[i] = (CW'(i) < n_use);
		end
	end

	assign busy      = (state_q != fts_pkg::ST_IDLE);
	assign issue     = (scan_q < n_use);
	assign tbl_raddr = scan_q[IW-1:0];
	assign slot_ok   = (32'(slot) < MAX_ENTRIES);
	assign do_load   = (state_q == fts_pkg::ST_IDLE) && start && !mode && slot_ok;
	assign do_tick   = (state_q == fts_pkg::ST_IDLE) && start && mode;
	assign run_stale = rv_q && ((CW'(run_q) >= n_use) || done_q[run_q]);

	// Shared compare and arithmetic on the entry read back from the table
	assign le_t        = (rd_arr <= now_q);
	assign t_minus_arr = now_q - rd_arr;
	assign w_inc       = (rd_wait == TMAX) ? rd_wait : rd_wait + TIME_BITS'(1);
	assign max_new     = (w_inc > rd_max) ? w_inc : rd_max;
	assign rem_new     = (rd_rem == '0) ? rd_rem : rd_rem - fts_pkg::REM_W'(1);
	assign t_inc       = (now_q == TMAX) ? now_q : now_q + TIME_BITS'(1);
	assign sw_inc      = (sw_q == SWMAX) ? sw_q : sw_q + fts_pkg::SW_W'(1);

	// Selection: earliest arrival, then lowest pid
	always_comb begin
		elig   = v_s1 && !done_q[idx_s1] && le_t;
		better = elig && (!found_q || (rd_arr < best_arr_q) ||
			((rd_arr == best_arr_q) && (rd_pid < best_pid_q)));
		found_d    = found_q | better;
		best_arr_d = better ? rd_arr : best_arr_q;
		best_pid_d = better ? rd_pid : best_pid_q;
		best_idx_d = better ? idx_s1 : best_idx_q;
	end

	// Update pass decode
	assign proc_upd = (state_q == fts_pkg::ST_UPD) && v_s1 && !done_q[idx_s1];
	assign is_run   = rv_q && (idx_s1 == run_q);

	// Drive table writes
	always_comb begin
		tbl_wr    = '0;
		tbl_waddr = idx_s1;
		tbl_wpid  = proc_id;
		tbl_warr  = TIME_BITS'(arrive_tick);
		tbl_wrem  = rem_new;
		tbl_wresp = t_minus_arr;
		tbl_wwait = is_run ? '0 : w_inc;
		tbl_wmax  = is_run ? rd_max : max_new;
		if (do_load) begin
			tbl_wr.load = 1'b1;
			tbl_waddr   = IW'(slot);
			tbl_wrem    = burst_time;
			tbl_wresp   = '0;
			tbl_wwait   = '0;
			tbl_wmax    = '0;
		end else if (proc_upd) begin
			if (is_run) begin
				tbl_wr.upd_wait = 1'b1;
				tbl_wr.upd_rem  = 1'b1;
				tbl_wr.upd_resp = !started_q[idx_s1];
			end else begin
				tbl_wr.upd_wait = le_t;
			end
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fts_pkg::ST_IDLE;
			scan_q       <= '0;
			v_s1         <= 1'b0;
			rv_q         <= 1'b0;
			run_q        <= '0;
			prev_v_q     <= 1'b0;
			prev_pid_q   <= '0;
			sw_q         <= '0;
			done_q       <= '0;
			started_q    <= '0;
			found_q      <= 1'b0;
			fin_q        <= 1'b0;
			now_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				fts_pkg::ST_IDLE: begin
					v_s1 <= 1'b0;
					if (do_load) begin
						done_q[IW'(slot)]    <= 1'b0;
						started_q[IW'(slot)] <= 1'b0;
						if (rv_q && (run_q == IW'(slot))) begin
							rv_q <= 1'b0;
						end
					end else if (do_tick) begin
						rv_q    <= rv_q && !run_stale;
						found_q <= 1'b0;
						fin_q   <= 1'b0;
						scan_q  <= '0;
						state_q <= (rv_q && !run_stale) ? fts_pkg::ST_UPD : fts_pkg::ST_SEL;
					end
				end
				fts_pkg::ST_SEL: begin
					found_q <= found_d;
					if (issue) begin
						scan_q <= scan_q + CW'(1);
						v_s1   <= 1'b1;
					end else begin
						// last entry compared: take the winner
						v_s1    <= 1'b0;
						scan_q  <= '0;
						state_q <= fts_pkg::ST_UPD;
						if (found_d) begin
							rv_q  <= 1'b1;
							run_q <= best_idx_d;
							if (!prev_v_q || (prev_pid_q != best_pid_d)) begin
								sw_q       <= sw_inc;
								prev_v_q   <= 1'b1;
								prev_pid_q <= best_pid_d;
							end
						end
					end
				end
				fts_pkg::ST_UPD: begin
					if (proc_upd && is_run) begin
						started_q[idx_s1] <= 1'b1;
						if (rem_new == '0) begin
							done_q[idx_s1] <= 1'b1;
							fin_q          <= 1'b1;
						end
					end
					if (issue) begin
						scan_q <= scan_q + CW'(1);
						v_s1   <= 1'b1;
					end else begin
						v_s1    <= 1'b0;
						state_q <= fts_pkg::ST_DONE;
					end
				end
				fts_pkg::ST_DONE: begin
					result_valid <= 1'b1;
					now_q        <= t_inc;
					rv_q         <= rv_q && !fin_q;
					if (!rv_q) begin
						prev_v_q <= 1'b0;
					end
					state_q <= fts_pkg::ST_IDLE;
				end
				default: begin
					state_q <= fts_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Scan stage, best candidate and result payload
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[IW-1:0];
		if (state_q == fts_pkg::ST_SEL) begin
			best_arr_q <= best_arr_d;
			best_pid_q <= best_pid_d;
			best_idx_q <= best_idx_d;
		end
		if (proc_upd && is_run) begin
			run_pid_q  <= rd_pid;
			resp_out_q <= started_q[idx_s1] ? rd_resp : t_minus_arr;
			lw_q       <= rd_max;
		end
		if (state_q == fts_pkg::ST_DONE) begin
			tick_time      <= fts_pkg::PORT_TW'(now_q);
			idle           <= !rv_q;
			running_id     <= rv_q ? run_pid_q : '0;
			finished       <= fin_q;
			done_tick      <= fin_q ? fts_pkg::PORT_TW'(t_inc) : '0;
			response_delay <= fin_q ? fts_pkg::PORT_TW'(resp_out_q) : '0;
			longest_wait   <= fin_q ? fts_pkg::PORT_TW'(lw_q) : '0;
			switch_count   <= sw_q;
			all_done       <= &(done_q | ~use_mask);
		end
	end

endmodule

// ----- sv/fcfs_tick_scheduler.sv -----
`timescale 1ns / 1ps

// First-come-first-served process scheduler, one time tick per command.
// Load command (start with mode 0): writes slot's pid, arrival and burst into
// the process table in the accept cycle; busy stays low and no result follows.
// Tick command (start with mode 1): busy rises for the tick. If nothing is
// running, one pass over the n entries in use picks the arrived, unfinished
// entry with the earliest arrival (lowest pid on a tie); a second pass runs
// that entry for one tick and updates the wait streaks of the others.
// Each pass reads one table entry per cycle through the table read port
// (n = num_processes, clamped to 1..MAX_ENTRIES); a tick that finds an
// entry already running skips the selection pass.
// The result is on the outputs for the single cycle in which result_valid is
// high; the receiver cannot stall it, and busy is low again in that cycle.
// cfg_we writes num_processes from cfg_data; write it only while idle.
// Reset clears time, counters, the running slot and the finished flags, and
// sets num_processes to 1; table contents are undefined until loaded.
module fcfs_tick_scheduler #(
	parameter int MAX_ENTRIES = 16,
	parameter int TIME_BITS   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fts_pkg::NP_W-1:0]        cfg_data,
	input  logic                            start,
	input  logic                            mode,
	input  logic [fts_pkg::SLOT_W-1:0]      slot,
	input  logic [fts_pkg::PID_W-1:0]       proc_id,
	input  logic [fts_pkg::PORT_TW-1:0]     arrive_tick,
	input  logic [fts_pkg::REM_W-1:0]       burst_time,
	output logic                            busy,
	output logic                            result_valid,
	output logic [fts_pkg::PORT_TW-1:0]     tick_time,
	output logic                            idle,
	output logic [fts_pkg::PID_W-1:0]       running_id,
	output logic                            finished,
	output logic [fts_pkg::PORT_TW-1:0]     done_tick,
	output logic [fts_pkg::PORT_TW-1:0]     response_delay,
	output logic [fts_pkg::PORT_TW-1:0]     longest_wait,
	output logic [fts_pkg::SW_W-1:0]        switch_count,
	output logic                            all_done
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [fts_pkg::NP_W-1:0]  num_proc_q;

	logic [IW-1:0]             tbl_raddr;
	logic [IW-1:0]             tbl_waddr;
	fts_pkg::tbl_wr_t          tbl_wr;
	logic [fts_pkg::PID_W-1:0] tbl_wpid;
	logic [TIME_BITS-1:0]      tbl_warr;
	logic [fts_pkg::REM_W-1:0] tbl_wrem;
	logic [TIME_BITS-1:0]      tbl_wresp;
	logic [TIME_BITS-1:0]      tbl_wwait;
	logic [TIME_BITS-1:0]      tbl_wmax;
	logic [fts_pkg::PID_W-1:0] rd_pid;
	logic [TIME_BITS-1:0]      rd_arr;
	logic [fts_pkg::REM_W-1:0] rd_rem;
	logic [TIME_BITS-1:0]      rd_resp;
	logic [TIME_BITS-1:0]      rd_wait;
	logic [TIME_BITS-1:0]      rd_max;

	// Hold the entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_proc_q <= fts_pkg::NP_W'(1);
		end else if (cfg_we) begin
			num_proc_q <= cfg_data;
		end
	end

	fts_table #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.TIME_BITS   (TIME_BITS)
	) u_table (
		.clk    (clk),
		.raddr  (tbl_raddr),
		.waddr  (tbl_waddr),
		.wr     (tbl_wr),
		.w_pid  (tbl_wpid),
		.w_arr  (tbl_warr),
		.w_rem  (tbl_wrem),
		.w_resp (tbl_wresp),
		.w_wait (tbl_wwait),
		.w_max  (tbl_wmax),
		.r_pid  (rd_pid),
		.r_arr  (rd_arr),
		.r_rem  (rd_rem),
		.r_resp (rd_resp),
		.r_wait (rd_wait),
		.r_max  (rd_max)
	);

	fts_core #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.TIME_BITS   (TIME_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.num_processes  (num_proc_q),
		.start          (start),
		.mode           (mode),
		.slot           (slot),
		.proc_id        (proc_id),
		.arrive_tick    (arrive_tick),
		.burst_time     (burst_time),
		.busy           (busy),
		.tbl_raddr      (tbl_raddr),
		.tbl_waddr      (tbl_waddr),
		.tbl_wr         (tbl_wr),
		.tbl_wpid       (tbl_wpid),
		.tbl_warr       (tbl_warr),
		.tbl_wrem       (tbl_wrem),
		.tbl_wresp      (tbl_wresp),
		.tbl_wwait      (tbl_wwait),
		.tbl_wmax       (tbl_wmax),
		.rd_pid         (rd_pid),
		.rd_arr         (rd_arr),
		.rd_rem         (rd_rem),
		.rd_resp        (rd_resp),
		.rd_wait        (rd_wait),
		.rd_max         (rd_max),
		.result_valid   (result_valid),
		.tick_time      (tick_time),
		.idle           (idle),
		.running_id     (running_id),
		.finished       (finished),
		.done_tick      (done_tick),
		.response_delay (response_delay),
		.longest_wait   (longest_wait),
		.switch_count   (switch_count),
		.all_done       (all_done)
	);

endmodule
